FILE: rtl/core/tkit_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the top-k itemset tracker.
// No dependencies; every other file imports this package.
package tkit_pkg;

	localparam int MASK_W = 64;
	localparam int UTIL_W = 48;
	localparam int IDX_W  = 4;
	localparam int CNT_W  = 5;

	localparam logic             KIND_OFFER = 1'b0;
	localparam logic             KIND_READ  = 1'b1;
	localparam logic [CNT_W-1:0] K_RESET    = 5'd10;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_LOW       = 3'd3,
		ST_READ      = 3'd4
	} tkit_status_t;

	// Class decided by the front end before the item is queued
	typedef enum logic [1:0] {
		CLS_OFFER = 2'd0,
		CLS_EMPTY = 2'd1,
		CLS_READ  = 2'd2
	} tkit_cls_t;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  entry_index;
		logic [MASK_W-1:0] item_mask;
		logic [UTIL_W-1:0] utility;
	} tkit_item_t;

	typedef struct packed {
		tkit_status_t      status;
		logic [IDX_W-1:0]  position;
		logic [CNT_W-1:0]  entry_count;
		logic [MASK_W-1:0] read_mask;
		logic [UTIL_W-1:0] read_utility;
	} tkit_result_t;

	typedef struct packed {
		tkit_cls_t         cls;
		logic [IDX_W-1:0]  entry_index;
		logic [MASK_W-1:0] item_mask;
		logic [UTIL_W-1:0] utility;
	} tkit_op_t;

endpackage

FILE: rtl/core/tkit_front.sv
`timescale 1ns / 1ps
// Front end: takes items, trims and classifies them, and holds them in a
// two-entry queue for the back end. Depends on tkit_pkg.
module tkit_front import tkit_pkg::*; #(
	parameter int MASK_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  tkit_item_t item,
	output logic       busy,
	output tkit_op_t   head,
	output logic       head_valid,
	input  logic       pop
);

	localparam logic [MASK_W-1:0] KEEP = MASK_W'({MASK_W{1'b1}} >> (MASK_W - MASK_BITS));

	tkit_op_t    op_in;
	tkit_op_t    slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  fill_q;
	logic        push;

	always_comb begin
		op_in.entry_index = item.entry_index;
		op_in.item_mask   = item.item_mask & KEEP;
		op_in.utility     = item.utility;
		if (item.kind == KIND_READ) begin
			op_in.cls = CLS_READ;
		end else if (item.utility == '0 || (item.item_mask & KEEP) == '0) begin
			op_in.cls = CLS_EMPTY;
		end else begin
			op_in.cls = CLS_OFFER;
		end
	end

	assign busy       = (fill_q == 2'd2);
	assign push       = start && !busy;
	assign head_valid = (fill_q != 2'd0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/core/tkit_back.sv
`timescale 1ns / 1ps
// Back end: the sorted entry row, parallel compare, shift-insert and result
// register. Depends on tkit_pkg; fed by tkit_front.
module tkit_back import tkit_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int MASK_BITS   = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	input  tkit_op_t         head,
	input  logic             head_valid,
	output logic             pop,
	output tkit_result_t     result,
	output logic             done
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_CMP = 2'b01,
		S_UPD = 2'b10
	} state_t;

	state_t state_q;

	logic [MASK_BITS-1:0] mask_q [MAX_ENTRIES];
	logic [UTIL_W-1:0]    util_q [MAX_ENTRIES];
	logic [CW-1:0]        count_q;
	logic [CNT_W-1:0]     k_q;

	// compare results
	logic [CW-1:0]        keff;
	logic                 room;
	logic [CW-1:0]        limit;
	logic [MAX_ENTRIES-1:0] ge;
	logic                 dup;
	logic                 last_gt;
	logic [CW-1:0]        pos;
	logic [MASK_W-1:0]    rmask;
	logic [UTIL_W-1:0]    rutil;

	// held for the update cycle
	tkit_cls_t            cls_s1;
	logic                 dup_s1;
	logic                 take_s1;
	logic                 room_s1;
	logic [CW-1:0]        pos_s1;
	logic [CW-1:0]        limit_s1;
	logic [MASK_BITS-1:0] mask_s1;
	logic [UTIL_W-1:0]    util_s1;
	logic [MASK_W-1:0]    rmask_s1;
	logic [UTIL_W-1:0]    rutil_s1;

	logic                 wr_en;
	logic [CW-1:0]        count_nx;
	tkit_result_t         res_d;

	assign pop = (state_q == S_CMP) && head_valid;

	always_comb begin
		if (k_q == '0) begin
			keff = CW'(1);
		end else if (int'(k_q) > MAX_ENTRIES) begin
			keff = CW'(MAX_ENTRIES);
		end else begin
			keff = CW'(k_q);
		end
		room  = count_q < keff;
		// slot that the offer competes for: the free one, or the last held
		limit = room ? count_q : count_q - CW'(1);
	end

	always_comb begin
		dup     = 1'b0;
		last_gt = 1'b0;
		rmask   = '0;
		rutil   = '0;
		pos     = '0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			ge[j] = (CW'(j) < limit) && (util_q[j] >= head.utility);
			if (CW'(j) < count_q) begin
				if (mask_q[j] == head.item_mask[MASK_BITS-1:0]) begin
					dup = 1'b1;
				end
				if (int'(head.entry_index) == j) begin
					rmask = MASK_W'(mask_q[j]);
					rutil = util_q[j];
				end
			end
			if (CW'(j) == count_q - CW'(1) && head.utility > util_q[j]) begin
				last_gt = 1'b1;
			end
		end
		// list is sorted, so the qualifying entries form a prefix: find its end
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if ((j == 0 || ge[(j > 0) ? j - 1 : 0]) && !ge[j]) begin
				pos = pos | CW'(j);
			end
		end
	end

	assign wr_en    = (state_q == S_UPD) && (cls_s1 == CLS_OFFER) && !dup_s1 && take_s1;
	assign count_nx = wr_en ? count_q + CW'(room_s1) : count_q;

	always_comb begin
		res_d.position     = '0;
		res_d.entry_count  = CNT_W'(count_nx);
		res_d.read_mask    = '0;
		res_d.read_utility = '0;
		case (cls_s1)
			CLS_READ: begin
				res_d.status       = ST_READ;
				res_d.read_mask    = rmask_s1;
				res_d.read_utility = rutil_s1;
			end
			CLS_EMPTY: begin
				res_d.status = ST_EMPTY;
			end
			CLS_OFFER: begin
				if (dup_s1) begin
					res_d.status = ST_DUPLICATE;
				end else if (take_s1) begin
					res_d.status   = ST_INSERTED;
					res_d.position = IDX_W'(pos_s1);
				end else begin
					res_d.status = ST_LOW;
				end
			end
			default: begin
				res_d.status = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_s1   <= head.cls;
			dup_s1   <= dup;
			take_s1  <= room || last_gt;
			room_s1  <= room;
			pos_s1   <= pos;
			limit_s1 <= limit;
			mask_s1  <= head.item_mask[MASK_BITS-1:0];
			util_s1  <= head.utility;
			rmask_s1 <= rmask;
			rutil_s1 <= rutil;
		end
		if (wr_en) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (CW'(j) == pos_s1) begin
					mask_q[j] <= mask_s1;
					util_q[j] <= util_s1;
				end else if (CW'(j) > pos_s1 && CW'(j) <= limit_s1) begin
					// shift lower-ranked entries down by one
					mask_q[j] <= mask_q[(j > 0) ? j - 1 : 0];
					util_q[j] <= util_q[(j > 0) ? j - 1 : 0];
				end
			end
		end
		if (state_q == S_UPD) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CMP;
			count_q <= '0;
			k_q     <= K_RESET;
			done    <= 1'b0;
		end else begin
			done <= (state_q == S_UPD);
			if (cfg_valid) begin
				k_q <= cfg_data;
			end
			count_q <= count_nx;
			case (state_q)
				S_CMP: begin
					if (head_valid) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_CMP;
				end
				default: begin
					state_q <= S_CMP;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/top_k_itemset_tracker.sv
`timescale 1ns / 1ps
// Top level of the top-k itemset tracker: front end, item queue and back end.
// Depends on tkit_pkg, tkit_front and tkit_back.
//
//  channel   handshake                 payload
//  -------   -----------------------   -------------------------------
//  input     start / busy              item   (tkit_item_t)
//  result    done (one-cycle strobe)   result (tkit_result_t)
//  config    cfg_valid / cfg_ready     cfg_data (k_in_use, 5 bits)
//
// The back end takes each item through a parallel compare over the entry row
// and then a shift-insert, and takes no new item until the shift-insert is done.
// An accepted item waits in the queue, behind any queued item, until S_CMP pops
// it; done and result are registered from S_UPD and taken while done is high.
// busy rises only when the two-entry queue is full.
// Reset clears the entry count and sets k_in_use to 10; entries need no clear.
// Results cannot be stalled; cfg_ready is always high.
module top_k_itemset_tracker import tkit_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int MASK_BITS   = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tkit_item_t       item,
	output logic             done,
	output tkit_result_t     result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	tkit_op_t head;
	logic     head_valid;
	logic     pop;

	assign cfg_ready = 1'b1;

	tkit_front #(
		.MASK_BITS (MASK_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	tkit_back #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MASK_BITS   (MASK_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result),
		.done       (done)
	);

`ifndef SYNTH
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results closer than two cycles apart");

	a_insert_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_INSERTED) |->
		(MAX_ENTRIES > 16 || result.position < result.entry_count))
		else $error("insert rank beyond entry count");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("queue filled without an accepted item");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_READ) |->
		(result.read_mask == '0 && result.read_utility == '0))
		else $error("read data on a non-read result");
`endif

endmodule

FILE: sim/tb_top_k_itemset_tracker.sv
`timescale 1ns / 1ps
// Self-checking bench for top_k_itemset_tracker: directed table, then random phases.
// Depends on tkit_pkg and the RTL top; carries its own model of the sorted top-k list.
module tb_top_k_itemset_tracker import tkit_pkg::*;;

	localparam int          LIST_DEPTH    = 16;
	localparam int          POOL_SIZE     = 16;
	localparam int          NUM_DIRECTED  = 27;
	localparam int          NUM_PHASES    = 6;
	localparam int          PHASE_ITEMS   = 185;
	localparam int          SETTLE_CYCLES = 6;
	localparam int          STALL_LIMIT   = 2000;
	localparam int          PRINT_LIMIT   = 40;
	localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [47:0] UTIL_TOP      = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		bit           is_cfg;
		logic [4:0]   k;
		tkit_item_t   it;
		bit           fixed;
		tkit_result_t res;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	tkit_item_t       item;
	logic             done;
	tkit_result_t     result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	// model of the list
	logic [MASK_W-1:0] list_mask [LIST_DEPTH];
	logic [UTIL_W-1:0] list_util [LIST_DEPTH];
	int                held = 0;
	logic [CNT_W-1:0]  k_setting = K_RESET;

	tkit_result_t      pending_results[$];
	bit                fixed_valid;
	tkit_result_t      fixed_result;
	int                idle_pct;
	int                fail_count = 0;
	int                stall_cycles = 0;
	logic [MASK_W-1:0] mask_pool [POOL_SIZE];
	stim_row_t         directed_rows [NUM_DIRECTED];
	int                phase_k [NUM_PHASES] = '{16, 1, 0, 2, 31, 7};
	int                phase_idle [NUM_PHASES] = '{0, 80, 17, 0, 80, 17};

	top_k_itemset_tracker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Predict the result of one accepted item and update the list.
	function automatic tkit_result_t track_item(input tkit_item_t it);
		tkit_result_t r;
		int           slot;
		int           k_eff;
		bit           seen;
		r = '0;
		r.status = ST_READ;
		if (it.kind == KIND_READ) begin
			if (int'(it.entry_index) < held) begin
				r.read_mask    = list_mask[it.entry_index];
				r.read_utility = list_util[it.entry_index];
			end
		end else if (it.utility == '0 || it.item_mask == '0) begin
			r.status = ST_EMPTY;
		end else begin
			seen = 1'b0;
			for (slot = 0; slot < held; slot++)
				if (list_mask[slot] == it.item_mask) seen = 1'b1;
			k_eff = (k_setting == 0) ? 1 : (k_setting > LIST_DEPTH) ? LIST_DEPTH : int'(k_setting);
			if (seen) begin
				r.status = ST_DUPLICATE;
			end else if (held < k_eff || it.utility > list_util[held-1]) begin
				if (held < k_eff) held++;
				slot = held - 1;
				// shift lower-utility entries down; ties stay ahead
				while (slot > 0 && list_util[slot-1] < it.utility) begin
					list_mask[slot] = list_mask[slot-1];
					list_util[slot] = list_util[slot-1];
					slot--;
				end
				list_mask[slot] = it.item_mask;
				list_util[slot] = it.utility;
				r.status   = ST_INSERTED;
				r.position = slot[IDX_W-1:0];
			end else begin
				r.status = ST_LOW;
			end
		end
		r.entry_count = held[CNT_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t offer_row(input logic [63:0] m, input logic [47:0] u);
		stim_row_t r;
		r = '{default: '0};
		r.it.kind      = KIND_OFFER;
		r.it.item_mask = m;
		r.it.utility   = u;
		return r;
	endfunction

	function automatic stim_row_t read_row(input logic [3:0] idx);
		stim_row_t r;
		r = '{default: '0};
		r.it.kind        = KIND_READ;
		r.it.entry_index = idx;
		return r;
	endfunction

	function automatic stim_row_t k_row(input logic [4:0] k);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.k      = k;
		return r;
	endfunction

	function automatic stim_row_t expecting(input stim_row_t row, input tkit_status_t st,
			input logic [3:0] pos, input logic [4:0] cnt, input logic [63:0] m,
			input logic [47:0] u);
		stim_row_t r;
		r = row;
		r.fixed = 1'b1;
		r.res   = '{st, pos, cnt, m, u};
		return r;
	endfunction

	function automatic tkit_item_t random_item();
		tkit_item_t  it;
		logic [63:0] noise;
		int          pick;
		noise          = {$urandom, $urandom};
		it.kind        = KIND_OFFER;
		it.entry_index = 4'($urandom_range(15));
		it.item_mask   = {$urandom, $urandom};
		it.utility     = noise[47:0];
		pick = $urandom_range(99);
		if (pick < 25) begin
			it.kind = KIND_READ;
		end else if (pick < 30) begin
			if ($urandom_range(1)) it.utility = '0;
			else it.item_mask = '0;
		end else begin
			pick = $urandom_range(99);
			if (pick < 40) it.item_mask = mask_pool[4'($urandom_range(POOL_SIZE-1))];
			else if (pick < 50) it.item_mask = 64'd1 << $urandom_range(63);
			// crowd utilities near the top and the bottom to force ties
			pick = $urandom_range(99);
			if (pick < 30) it.utility = 48'($urandom_range(1, 8));
			else if (pick < 65) it.utility = UTIL_TOP - 48'($urandom_range(15));
		end
		return it;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
	endtask

	// Call at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(input tkit_item_t it, input bit has_fixed,
			input tkit_result_t fixed);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start        = 1'b1;
		item         = it;
		fixed_valid  = has_fixed;
		fixed_result = fixed;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_k(input logic [4:0] k);
		cfg_valid = 1'b1;
		cfg_data  = k;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Check results first: a result never belongs to an item taken at the same edge.
	always @(posedge clk) begin
		tkit_result_t want;
		tkit_result_t got;
		if (arst_n) begin
			if (done) begin
				got = result;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", 64'(got.status), 64'd0);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.position !== want.position)
						report_mismatch("position", 64'(got.position), 64'(want.position));
					if (got.entry_count !== want.entry_count)
						report_mismatch("entry_count", 64'(got.entry_count),
							64'(want.entry_count));
					if (got.read_mask !== want.read_mask)
						report_mismatch("read_mask", got.read_mask, want.read_mask);
					if (got.read_utility !== want.read_utility)
						report_mismatch("read_utility", 64'(got.read_utility),
							64'(want.read_utility));
				end
			end
			if (cfg_valid && cfg_ready) k_setting = cfg_data;
			if (start && !busy) begin
				want = track_item(item);
				pending_results.push_back(fixed_valid ? fixed_result : want);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int          ph;
		int          n;
		tkit_item_t  it;
		logic [63:0] m;
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		idle_pct     = 0;
		fixed_valid  = 1'b0;
		fixed_result = '0;

		directed_rows = '{
			expecting(read_row(4'd0), ST_READ, 4'd0, 5'd0, 64'd0, 48'd0),
			expecting(offer_row(ALL_ONES, 48'd0), ST_EMPTY, 4'd0, 5'd0, 64'd0, 48'd0),
			expecting(offer_row(64'd0, UTIL_TOP), ST_EMPTY, 4'd0, 5'd0, 64'd0, 48'd0),
			expecting(offer_row(ALL_ONES, UTIL_TOP), ST_INSERTED, 4'd0, 5'd1, 64'd0, 48'd0),
			expecting(offer_row(ALL_ONES, 48'd5), ST_DUPLICATE, 4'd0, 5'd1, 64'd0, 48'd0),
			expecting(read_row(4'd0), ST_READ, 4'd0, 5'd1, ALL_ONES, UTIL_TOP),
			expecting(read_row(4'd15), ST_READ, 4'd0, 5'd1, 64'd0, 48'd0),
			expecting(offer_row(64'd1, 48'd1), ST_INSERTED, 4'd1, 5'd2, 64'd0, 48'd0),
			expecting(offer_row(64'd2, 48'd1), ST_INSERTED, 4'd2, 5'd3, 64'd0, 48'd0),
			offer_row(64'h8000_0000_0000_0000, 48'h100),
			// lower k below the count: the list is now full
			k_row(5'd3),
			offer_row(64'd4, 48'd1),
			offer_row(64'd8, 48'd2),
			// zero acts as one, held entries stay readable
			k_row(5'd0),
			offer_row(64'd16, 48'd3),
			read_row(4'd2),
			offer_row(64'h5555_5555_5555_5555, 48'd1),
			offer_row(64'd16, 48'd9),
			// above the depth acts as the depth
			k_row(5'd31),
			offer_row(64'hAAAA_AAAA_AAAA_AAAA, 48'h8000_0000_0000),
			offer_row(64'h0000_0001_0000_0000, 48'h7FFF_FFFF_FFFF),
			read_row(4'd1),
			read_row(4'd4),
			read_row(4'd5),
			k_row(5'd16),
			offer_row(64'hFFFF_FFFF_0000_0000, 48'd1),
			read_row(4'd15)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_for_results();
				write_k(directed_rows[i].k);
			end else begin
				send_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].res);
			end
		end

		foreach (mask_pool[i]) begin
			m = {$urandom, $urandom};
			mask_pool[i] = (m == '0) ? 64'd1 : m;
		end
		phase_k[NUM_PHASES-1] = $urandom_range(31);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_for_results();
			write_k(phase_k[ph][4:0]);
			idle_pct = phase_idle[ph];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// hold off until the pipeline is empty, once per phase
				if (n == PHASE_ITEMS / 2) wait_for_results();
				it = random_item();
				send_item(it, 1'b0, '0);
			end
		end

		idle_pct = 0;
		wait_for_results();
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
